@@ sv/fmrm_pkg.sv @@
// package for the moving-average frame rate meter
// field widths, register indexes, reset values and divider status shared by the meter, divider and checker
// no dependencies
package fmrm_pkg;

	// fixed field widths
	localparam int STAMP_W     = 64;
	localparam int TICK_W      = 32;
	localparam int RATE_W      = 32;
	localparam int FRAC_W      = 8;
	localparam int LEN_FIELD_W = 9;
	localparam int CFG_W       = 32;
	localparam int IDX_W       = 1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
	localparam logic [IDX_W-1:0] REG_TICK_RATE  = 1'b1;

	// register reset values
	localparam logic [LEN_FIELD_W-1:0] LEN_RESET  = 9'd60;
	localparam logic [TICK_W-1:0]      TICK_RESET = 32'd10000000;

	// divider status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ sv/moving_average_frame_rate_meter_top.sv @@
// Frame rate meter: each beat on the input carries one free-running timestamp; each
// result beat gives window_len * tick_rate * 256 / (sum of the last window_len tick
// deltas), saturated to 32 bits, with rate_valid high. The first stamp after reset and a
// stamp equal to the previous one give 0 with rate_valid low and leave the window alone.
// An updating stamp runs through the update, start, wait and done states, its result
// set by the one-bit-per-cycle divider; a non-updating stamp goes from update to done.
// One stamp is in flight at a time; a finished result may wait in the output register
// while the next stamp is accepted. The delta ring sits in a registered-read ram;
// entries not yet written since reset or a window_len write read as zero, tracked by a
// wrap flag, so no clearing pass is needed. Writing window_len clears the window.
// depends on fmrm_pkg, fmrm_ram and fmrm_div
module moving_average_frame_rate_meter_top
	import fmrm_pkg::*;
#(
	parameter int WINDOW_MAX = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [STAMP_W-1:0] frame_stamp,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [RATE_W-1:0]  rate_q8,
	output logic               rate_valid
);

	localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
	localparam int POS_W  = $clog2(WINDOW_MAX);
	localparam int SUM_W  = TICK_W + POS_W;
	localparam int PROD_W = LEN_W + TICK_W;
	localparam int NUM_W  = PROD_W + FRAC_W;
	localparam int CMP_W  = LEN_FIELD_W + LEN_W;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_UPD   = 5'b00010,
		S_START = 5'b00100,
		S_WAIT  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	// zero acts as one, anything above the ring depth acts as the depth
	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_FIELD_W-1:0] v);
		logic [LEN_W-1:0] r;
		if (v == '0) begin
			r = LEN_W'(1);
		end else if (CMP_W'(v) > CMP_W'(WINDOW_MAX)) begin
			r = LEN_W'(WINDOW_MAX);
		end else begin
			r = LEN_W'(v);
		end
		return r;
	endfunction

	state_t             state_q;
	logic [LEN_W-1:0]   len_q;
	logic [TICK_W-1:0]  tick_q;
	logic [STAMP_W-1:0] last_stamp_q;
	logic               have_last_q;
	logic [POS_W-1:0]   pos_q;
	logic               wrapped_q;
	logic [SUM_W-1:0]   sum_q;
	logic [PROD_W-1:0]  prod_q;
	logic [TICK_W-1:0]  d32_s1;
	logic               skip_s1;
	logic [RATE_W-1:0]  res_q;
	logic               res_valid_q;
	logic               out_valid_q;
	logic [RATE_W-1:0]  rate_q;
	logic               rate_valid_q;

	logic               accept;
	logic [STAMP_W-1:0] delta;
	logic [TICK_W-1:0]  rdata;
	logic [TICK_W-1:0]  old_delta;
	logic [LEN_W-1:0]   pos_inc;
	logic               pos_wrap;
	logic               ram_we;
	logic [PROD_W-1:0]  prod;
	logic               load_out;
	div_stat_t          div_stat;
	logic [NUM_W-1:0]   quo;
	logic [RATE_W-1:0]  quo_sat;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	// tick delta modulo 2^64
	assign delta = frame_stamp - last_stamp_q;

	// unwritten slots read as zero until the ring has wrapped once
	assign old_delta = wrapped_q ? rdata : '0;
	assign pos_inc   = LEN_W'(pos_q) + LEN_W'(1);
	assign pos_wrap  = pos_inc >= len_q;
	assign ram_we    = (state_q == S_UPD) && !skip_s1;
	assign prod      = PROD_W'(len_q) * PROD_W'(tick_q);

	fmrm_ram #(
		.WIDTH (TICK_W),
		.DEPTH (WINDOW_MAX)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q),
		.wdata (d32_s1),
		.re    (accept),
		.raddr (pos_q),
		.rdata (rdata)
	);

	fmrm_div #(
		.NUM_W (NUM_W),
		.DEN_W (SUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_START),
		.num    ({prod_q, {FRAC_W{1'b0}}}),
		.den    (sum_q),
		.stat   (div_stat),
		.quo    (quo)
	);

	// saturate the quotient to the result width
	assign quo_sat = (|quo[NUM_W-1:RATE_W]) ? '1 : quo[RATE_W-1:0];

	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// sequencer, configuration and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			len_q        <= clamp_len(LEN_RESET);
			tick_q       <= TICK_RESET;
			last_stamp_q <= '0;
			have_last_q  <= 1'b0;
			pos_q        <= '0;
			wrapped_q    <= 1'b0;
			sum_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WINDOW_LEN: begin
						len_q     <= clamp_len(cfg_data[LEN_FIELD_W-1:0]);
						pos_q     <= '0;
						wrapped_q <= 1'b0;
						sum_q     <= '0;
					end
					REG_TICK_RATE: begin
						tick_q <= cfg_data[TICK_W-1:0];
					end
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_stamp_q <= frame_stamp;
						have_last_q  <= 1'b1;
						state_q      <= S_UPD;
					end
				end
				S_UPD: begin
					if (skip_s1) begin
						state_q <= S_DONE;
					end else begin
						sum_q <= sum_q - SUM_W'(old_delta) + SUM_W'(d32_s1);
						if (pos_wrap) begin
							pos_q     <= '0;
							wrapped_q <= 1'b1;
						end else begin
							pos_q <= pos_inc[POS_W-1:0];
						end
						state_q <= S_START;
					end
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_stat.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// accepted stamp: saturated delta and the no-update flag
	always_ff @(posedge clk) begin
		if (accept) begin
			d32_s1  <= (|delta[STAMP_W-1:TICK_W]) ? '1 : delta[TICK_W-1:0];
			skip_s1 <= !have_last_q || (delta == '0);
		end
	end

	// product of length and tick rate, and the pending result
	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			prod_q      <= prod;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else if ((state_q == S_WAIT) && div_stat.done) begin
			res_q       <= quo_sat;
			res_valid_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rate_q       <= res_q;
			rate_valid_q <= res_valid_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign rate_q8    = rate_q;
	assign rate_valid = rate_valid_q;

	// an accepted beat always moves straight to the window update
	a_accept_to_upd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_UPD)
		else $error("accepted beat did not enter the update step");

	// the divider only reports completion while it is being waited on
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_WAIT)
		else $error("divider finished outside the wait state");

	// the ring position stays inside the current window
	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		LEN_W'(pos_q) < len_q)
		else $error("ring position beyond window length");

	// a division is never started on an empty window
	a_sum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_START |-> sum_q != '0)
		else $error("division started with zero window sum");

	// a non-updating result carries a zero rate
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rate_valid |-> rate_q8 == '0)
		else $error("rate nonzero with rate_valid low");

endmodule

@@ sv/fmrm_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing
module fmrm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/fmrm_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
// depends on fmrm_pkg for the status struct
module fmrm_div
	import fmrm_pkg::*;
#(
	parameter int NUM_W = 49,
	parameter int DEN_W = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output div_stat_t        stat,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   rem_shift;
	logic             ge;
	logic [DEN_W:0]   rem_next;

	// trial subtract of the shifted remainder
	assign rem_shift = {rem_q, quo_q[NUM_W-1]};
	assign ge        = rem_shift >= {1'b0, den_q};
	assign rem_next  = ge ? (rem_shift - {1'b0, den_q}) : rem_shift;

	// control: bit counter, busy and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: numerator bits shift out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= rem_next[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

@@ tb/fmrm_checker.sv @@
// checker for the frame rate meter: watches the register port and both channels,
// predicts every result beat and compares it with the beat the block gives
// depends on fmrm_pkg
module fmrm_checker
	import fmrm_pkg::*;
#(
	parameter int WINDOW_MAX = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [STAMP_W-1:0] frame_stamp,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [RATE_W-1:0]  rate_q8,
	input  logic               rate_valid,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic              valid;
	} rate_beat_t;

	// meter state as the block should hold it
	logic [STAMP_W-1:0] prev_stamp;
	logic               stamp_seen;
	logic [31:0]        delta_hist [WINDOW_MAX];
	int unsigned        hist_pos;
	logic [63:0]        hist_sum;
	int unsigned        cur_len;
	logic [TICK_W-1:0]  cur_tick;

	// rates still owed by the block, oldest first
	rate_beat_t rate_queue [$];

	// a written length of zero means one, anything past the ring size means the ring size
	function automatic int unsigned clamp_len(input logic [LEN_FIELD_W-1:0] v);
		if (v == '0)
			return 1;
		if (int'(v) > WINDOW_MAX)
			return WINDOW_MAX;
		return int'(v);
	endfunction

	task automatic clear_window();
		for (int i = 0; i < WINDOW_MAX; i++)
			delta_hist[i] = '0;
		hist_pos = 0;
		hist_sum = '0;
	endtask

	// one stamp in, one rate out; the window moves only on a nonzero delta
	task automatic meter_step(input logic [STAMP_W-1:0] stamp, output rate_beat_t beat);
		logic [63:0] delta;
		logic [31:0] d32;
		int unsigned pos;
		logic [63:0] num;
		logic [63:0] quo;
		beat = '0;
		if (!stamp_seen) begin
			prev_stamp = stamp;
			stamp_seen = 1'b1;
		end else begin
			delta = stamp - prev_stamp;
			prev_stamp = stamp;
			if (delta != '0) begin
				d32 = (delta > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : delta[31:0];
				pos = hist_pos;
				if (pos >= cur_len)
					pos = 0;
				hist_sum = hist_sum - 64'(delta_hist[pos]) + 64'(d32);
				delta_hist[pos] = d32;
				pos++;
				if (pos >= cur_len)
					pos = 0;
				hist_pos = pos;
				num = 64'(cur_len) * 64'(cur_tick) * 64'd256;
				quo = num / hist_sum;
				beat.rate = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
				beat.valid = 1'b1;
			end
		end
	endtask

	// sample both channels and the register port at each rising edge
	always @(posedge clk or negedge arst_n) begin : watch
		rate_beat_t want;
		if (!arst_n) begin
			prev_stamp = '0;
			stamp_seen = 1'b0;
			cur_len = clamp_len(LEN_RESET);
			cur_tick = TICK_RESET;
			clear_window();
			rate_queue.delete();
			errors = 0;
			pending = 0;
		end else begin
			// result beat against the oldest expectation
			if (out_valid && out_ready) begin
				if (rate_queue.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result beat: rate_q8 %h rate_valid %b",
							rate_q8, rate_valid);
				end else begin
					want = rate_queue[0];
					rate_queue.delete(0);
					if (rate_q8 !== want.rate || rate_valid !== want.valid) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: rate_q8 %h exp %h, rate_valid %b exp %b",
								rate_q8, want.rate, rate_valid, want.valid);
					end
				end
			end
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW_LEN: begin
						cur_len = clamp_len(cfg_data[LEN_FIELD_W-1:0]);
						clear_window();
					end
					REG_TICK_RATE: cur_tick = cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end
			// stamp beat
			if (in_valid && in_ready) begin
				meter_step(frame_stamp, want);
				rate_queue.insert(rate_queue.size(), want);
			end
			pending = rate_queue.size();
		end
	end

endmodule

@@ tb/tb.sv @@
// top of the frame rate meter testbench: clock, reset, stamp and register stimulus, verdict
// depends on fmrm_pkg, moving_average_frame_rate_meter_top and fmrm_checker
module tb;
	import fmrm_pkg::*;

	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 104;
	localparam int LONG_HOLD   = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 60;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [STAMP_W-1:0] frame_stamp;
	logic               out_valid;
	logic               out_ready;
	logic [RATE_W-1:0]  rate_q8;
	logic               rate_valid;

	int                 errors;
	int                 pending;
	int                 quiet_cycles = 0;
	bit                 tx_idle_en;
	bit                 rx_idle_en;
	bit                 long_hold_req;
	logic [STAMP_W-1:0] last_sent;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	moving_average_frame_rate_meter_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.frame_stamp (frame_stamp),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rate_q8     (rate_q8),
		.rate_valid  (rate_valid)
	);

	fmrm_checker i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.frame_stamp (frame_stamp),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rate_q8     (rate_q8),
		.rate_valid  (rate_valid),
		.errors      (errors),
		.pending     (pending)
	);

	// offer one stamp beat, with an optional gap first; returns at the accepting edge
	task automatic send_stamp(input logic [STAMP_W-1:0] s);
		int gap;
		gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? $urandom_range(1, 17) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			frame_stamp <= {$urandom, $urandom};
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		frame_stamp <= s;
		last_sent = s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic hold_input();
		@(negedge clk);
		in_valid <= 1'b0;
		frame_stamp <= {$urandom, $urandom};
	endtask

	// stop offering and wait until every owed rate has come back
	task automatic drain();
		hold_input();
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_regs(input bit do_len, input logic [CFG_W-1:0] len_d,
		input bit do_tick, input logic [CFG_W-1:0] tick_d);
		if (do_len) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= REG_WINDOW_LEN;
			cfg_data <= len_d;
		end
		if (do_tick) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= REG_TICK_RATE;
			cfg_data <= tick_d;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_index <= IDX_W'($urandom_range(0, 1));
		cfg_data <= $urandom;
	endtask

	// mostly a steady frame stream, with repeats, huge gaps, wraps and wild stamps mixed in
	function automatic logic [STAMP_W-1:0] next_stamp();
		int unsigned pick;
		logic [63:0] ticks;
		pick = $urandom_range(0, 99);
		ticks = 64'($urandom) >> $urandom_range(0, 31);
		if (ticks == '0)
			ticks = 64'd1;
		if (pick < 70)
			return last_sent + ticks;
		else if (pick < 78)
			return last_sent;
		else if (pick < 84)
			return last_sent + {32'($urandom_range(1, 32'hFFFF)), 32'($urandom)};
		else if (pick < 90)
			return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 100000));
		else
			return {$urandom, $urandom};
	endfunction

	function automatic logic [CFG_W-1:0] pick_len();
		case ($urandom_range(0, 7))
			0: return 32'd1;
			1: return 32'd2;
			2: return 32'd0;
			3: return 32'd256;
			4: return 32'($urandom_range(257, 511));
			5: return 32'($urandom_range(1, 16));
			6: return 32'($urandom_range(1, 256));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_tick();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return 32'd10_000_000;
			4: return 32'd1000;
			default: return $urandom;
		endcase
	endfunction

	// receiver: long hold on request, else random ready bursts when idling is on
	initial begin : receiver
		int hold_left;
		int burst_left;
		logic burst_ready;
		hold_left = 0;
		burst_left = 0;
		burst_ready = 1'b1;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (!rx_idle_en) begin
				out_ready <= 1'b1;
			end else begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 17);
					burst_ready = 1'($urandom_range(0, 1));
				end
				burst_left--;
				out_ready <= burst_ready;
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL moving_average_frame_rate_meter_top");
				$finish;
			end
		end
	end

	initial begin : stimulus
		bit do_len;
		bit do_tick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		frame_stamp = '0;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		long_hold_req = 1'b0;
		last_sent = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// first stamp, repeated stamp, plain and huge deltas, counter wrap
		send_stamp(64'd1000);
		send_stamp(64'd1000);
		send_stamp(64'd167667);
		send_stamp(64'd167668);
		send_stamp(64'd167668 + 64'h100_0000_0000);
		send_stamp(64'hFFFF_FFFF_FFFF_FF00);
		send_stamp(64'h0000_0000_0000_0100);
		send_stamp(64'hFFFF_FFFF_FFFF_FFFF);
		send_stamp(64'h0);
		drain();
		// shortest window at the top tick rate saturates; a length write keeps the last stamp
		set_regs(1'b1, 32'd1, 1'b1, 32'hFFFF_FFFF);
		send_stamp(64'd1);
		send_stamp(64'h1_0000_0001);
		drain();
		// zero tick rate gives zero with rate_valid high
		set_regs(1'b0, '0, 1'b1, 32'd0);
		send_stamp(last_sent + 64'd5);
		drain();
		// window length zero acts as one
		set_regs(1'b1, 32'd0, 1'b1, 32'd1);
		send_stamp(last_sent + 64'd1);
		send_stamp(last_sent + 64'd3);
		drain();
		// oversized length clamps to the ring size, upper data bits ignored
		set_regs(1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		repeat (4) send_stamp(last_sent + 64'($urandom_range(1, 3)));
		drain();
		set_regs(1'b1, 32'd256, 1'b1, 32'd10_000_000);
		repeat (3) send_stamp(last_sent + 64'd166_667);
		send_stamp(last_sent);
		drain();

		// random phases, each under a fresh register setting
		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			do_len = 1'($urandom_range(0, 1));
			do_tick = 1'($urandom_range(0, 1));
			if (!do_len && !do_tick)
				do_tick = 1'b1;
			set_regs(do_len, pick_len(), do_tick, pick_tick());
			tx_idle_en = (p != 2 && p != N_PHASES - 1);
			rx_idle_en = tx_idle_en;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// receiver holds off while stamps keep coming
				if (p == 3 && k == 10)
					long_hold_req = 1'b1;
				// sender pauses until the block has given everything back
				if (p == 5 && k == 50)
					drain();
				send_stamp(next_stamp());
			end
		end

		hold_input();
		while (pending != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS moving_average_frame_rate_meter_top");
		else
			$display("FAIL moving_average_frame_rate_meter_top");
		$finish;
	end

endmodule
